// File: sv/rpc_pkg.sv
// rpc_pkg: shared constants and the arctangent table for the rectangular/polar
// CORDIC converter. No dependencies; imported by rect_polar_converter.
package rpc_pkg;

	// internal vector and angle word: Q8.8 shifted up by 14, angles with 30 fraction bits
	localparam int VEC_W        = 34;
	localparam int TABLE_LEN    = 24;
	localparam int ITER_DEFAULT = 16;

	localparam logic [29:0]              GAIN_K      = 30'h26DD3B6A;
	localparam logic signed [VEC_W-1:0]  HALF_PI_Q30 = 34'sh06487ED51;
	localparam logic signed [15:0]       PI_Q13      = 16'sd25736;

	// atan(2^-i) scaled by 2^30, truncated
	function automatic logic [29:0] atan_lut(input logic [4:0] idx);
		logic [29:0] r;
		unique case (idx)
			5'd0:    r = 30'h3243F6A8;
			5'd1:    r = 30'h1DAC6705;
			5'd2:    r = 30'h0FADBAFC;
			5'd3:    r = 30'h07F56EA6;
			5'd4:    r = 30'h03FEAB76;
			5'd5:    r = 30'h01FFD55B;
			5'd6:    r = 30'h00FFFAAA;
			5'd7:    r = 30'h007FFF55;
			5'd8:    r = 30'h003FFFEA;
			5'd9:    r = 30'h001FFFFD;
			5'd10:   r = 30'h000FFFFF;
			5'd11:   r = 30'h0007FFFF;
			5'd12:   r = 30'h0003FFFF;
			5'd13:   r = 30'h0001FFFF;
			5'd14:   r = 30'h0000FFFF;
			5'd15:   r = 30'h00007FFF;
			5'd16:   r = 30'h00003FFF;
			5'd17:   r = 30'h00001FFF;
			5'd18:   r = 30'h00000FFF;
			5'd19:   r = 30'h000007FF;
			5'd20:   r = 30'h000003FF;
			5'd21:   r = 30'h000001FF;
			5'd22:   r = 30'h000000FF;
			5'd23:   r = 30'h0000007F;
			default: r = 30'h0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/rect_polar_converter.sv
// rect_polar_converter: pipelined CORDIC converter between rectangular and polar form.
// Depends on rpc_pkg for the gain, pi constants and the arctangent table.

// Fully pipelined: one transaction is accepted every cycle while the pipeline is not stalled,
// and its result passes through these registers in order: input decode and gain multiply,
// quadrant fold, one register per CORDIC step, output gain multiply, rounding into the output register.
// The step count is capped at the 24 entries of the arctangent table.
// Each stage holds its item while the stage after it is full and stalled, so empty
// stages keep filling while a result waits on m_tready. s_tuser is the mode (0: x,y
// in, radius and atan2 angle out; 1: radius and angle in, x and y out). m_tuser is the
// range error flag, set for a negative radius or an angle beyond +/-pi, in which case
// all data fields are zero. Fields that do not belong to the mode are zero.
module rect_polar_converter #(
	parameter int unsigned ITERATIONS = rpc_pkg::ITER_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] first_value, [31:16] second_value
	input  logic [0:0]  s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [15:0] radius_out, [31:16] angle_out, [47:32] x_out, [63:48] y_out
	output logic [0:0]  m_tuser    // [0] range_error
);
	import rpc_pkg::*;

	// never run past the end of the arctangent table
	localparam int N = (ITERATIONS < TABLE_LEN) ? int'(ITERATIONS) : TABLE_LEN;

	// ---------------- enables ----------------
	logic v_s1, v_s2, v_s4, v_s5;
	logic en1, en2, en4, en5;
	logic cv_s3 [N];
	logic en_c  [N];

	assign en5      = !v_s5 || m_tready;
	assign en4      = !v_s4 || en5;
	assign en2      = !v_s2 || en_c[0];
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	// ---------------- stage 1: decode, left half-plane fold, radius gain ----------------
	logic signed [15:0]       a_in, b_in;
	logic signed [VEC_W-1:0]  xa, yb, zb;
	logic signed [VEC_W-1:0]  x_c1, y_c1, z_c1;
	logic signed [46:0]       prod_c1;
	logic                     err_c1, zero_c1;

	logic signed [VEC_W-1:0]  x_s1, y_s1, z_s1;
	logic signed [46:0]       prod_s1;
	logic                     mode_s1, kill_s1, err_s1;

	assign a_in = s_tdata[15:0];
	assign b_in = s_tdata[31:16];
	assign xa   = {{(VEC_W-30){a_in[15]}}, a_in, 14'd0};
	assign yb   = {{(VEC_W-30){b_in[15]}}, b_in, 14'd0};
	assign zb   = {{(VEC_W-33){b_in[15]}}, b_in, 17'd0};

	assign prod_c1 = a_in * $signed({1'b0, GAIN_K});
	assign err_c1  = s_tuser[0] && (a_in < 16'sd0 || b_in > PI_Q13 || b_in < -PI_Q13);
	assign zero_c1 = !s_tuser[0] && a_in == 16'sd0 && b_in == 16'sd0;

	always_comb begin
		if (s_tuser[0]) begin
			x_c1 = '0;
			y_c1 = '0;
			z_c1 = zb;
		end else if (a_in[15]) begin
			// turn by a quarter so the vector lands in the right half-plane
			if (!b_in[15]) begin
				x_c1 = yb;
				y_c1 = -xa;
				z_c1 = HALF_PI_Q30;
			end else begin
				x_c1 = -yb;
				y_c1 = xa;
				z_c1 = -HALF_PI_Q30;
			end
		end else begin
			x_c1 = xa;
			y_c1 = yb;
			z_c1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1    <= x_c1;
			y_s1    <= y_c1;
			z_s1    <= z_c1;
			prod_s1 <= prod_c1;
			mode_s1 <= s_tuser[0];
			kill_s1 <= err_c1 || zero_c1;
			err_s1  <= err_c1;
		end
	end

	// ---------------- stage 2: scaled radius and angle fold for rotation ----------------
	logic signed [46:0]       rsum_c2;
	logic signed [VEC_W-1:0]  xr_c2;
	logic signed [VEC_W-1:0]  x_c2, y_c2, z_c2;
	logic signed [VEC_W-1:0]  x_s2, y_s2, z_s2;
	logic                     mode_s2, kill_s2, err_s2;

	assign rsum_c2 = prod_s1 + 47'sd32768;
	assign xr_c2   = {{(VEC_W-31){rsum_c2[46]}}, rsum_c2[46:16]};

	always_comb begin
		if (!mode_s1) begin
			x_c2 = x_s1;
			y_c2 = y_s1;
			z_c2 = z_s1;
		end else if (z_s1 > HALF_PI_Q30) begin
			x_c2 = '0;
			y_c2 = xr_c2;
			z_c2 = z_s1 - HALF_PI_Q30;
		end else if (z_s1 < -HALF_PI_Q30) begin
			x_c2 = '0;
			y_c2 = -xr_c2;
			z_c2 = z_s1 + HALF_PI_Q30;
		end else begin
			x_c2 = xr_c2;
			y_c2 = '0;
			z_c2 = z_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			x_s2    <= x_c2;
			y_s2    <= y_c2;
			z_s2    <= z_c2;
			mode_s2 <= mode_s1;
			kill_s2 <= kill_s1;
			err_s2  <= err_s1;
		end
	end

	// ---------------- stage 3: one register per CORDIC step ----------------
	logic signed [VEC_W-1:0] cx_s3 [N];
	logic signed [VEC_W-1:0] cy_s3 [N];
	logic signed [VEC_W-1:0] cz_s3 [N];
	logic                    cm_s3 [N];
	logic                    ck_s3 [N];
	logic                    ce_s3 [N];

	for (genvar g = 0; g < N; g++) begin : g_step
		logic signed [VEC_W-1:0] xi, yi, zi, xn, yn, zn, xsh, ysh, atn;
		logic                    mi, ki, ei, vi, dir;

		if (g == 0) begin : g_first
			assign xi = x_s2;
			assign yi = y_s2;
			assign zi = z_s2;
			assign mi = mode_s2;
			assign ki = kill_s2;
			assign ei = err_s2;
			assign vi = v_s2;
		end else begin : g_next
			assign xi = cx_s3[g-1];
			assign yi = cy_s3[g-1];
			assign zi = cz_s3[g-1];
			assign mi = cm_s3[g-1];
			assign ki = ck_s3[g-1];
			assign ei = ce_s3[g-1];
			assign vi = cv_s3[g-1];
		end

		if (g == N - 1) begin : g_last_en
			assign en_c[g] = !cv_s3[g] || en4;
		end else begin : g_mid_en
			assign en_c[g] = !cv_s3[g] || en_c[g+1];
		end

		assign xsh = xi >>> g;
		assign ysh = yi >>> g;
		assign atn = $signed({{(VEC_W-30){1'b0}}, atan_lut(5'(g))});
		// rotation with z >= 0 and vectoring with y < 0 turn the same way
		assign dir = mi ? !zi[VEC_W-1] : yi[VEC_W-1];

		always_comb begin
			if (dir) begin
				xn = xi - ysh;
				yn = yi + xsh;
				zn = zi - atn;
			end else begin
				xn = xi + ysh;
				yn = yi - xsh;
				zn = zi + atn;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s3[g] <= 1'b0;
			end else if (en_c[g]) begin
				cv_s3[g] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en_c[g]) begin
				cx_s3[g] <= xn;
				cy_s3[g] <= yn;
				cz_s3[g] <= zn;
				cm_s3[g] <= mi;
				ck_s3[g] <= ki;
				ce_s3[g] <= ei;
			end
		end
	end

	// ---------------- stage 4: magnitude gain, angle and x/y rounding ----------------
	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	logic signed [VEC_W-1:0] xf, yf, zf, zs_c4, xs_c4, ys_c4;
	logic signed [16:0]      zr_c4;
	logic signed [15:0]      ang_c4;
	logic [60:0]             rprod_c4;

	logic [60:0]             rprod_s4;
	logic signed [15:0]      ang_s4, xo_s4, yo_s4;
	logic                    mode_s4, kill_s4, err_s4;

	assign xf = cx_s3[N-1];
	assign yf = cy_s3[N-1];
	assign zf = cz_s3[N-1];

	// vectoring leaves x non-negative and below 2^31
	assign rprod_c4 = xf[30:0] * GAIN_K;
	assign zs_c4    = zf + 34'sd65536;
	assign zr_c4    = zs_c4[VEC_W-1:17];
	assign xs_c4    = xf + 34'sd8192;
	assign ys_c4    = yf + 34'sd8192;

	always_comb begin
		if (zr_c4 > 17'(PI_Q13)) begin
			ang_c4 = PI_Q13;
		end else if (zr_c4 < -17'(PI_Q13)) begin
			ang_c4 = -PI_Q13;
		end else begin
			ang_c4 = zr_c4[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= cv_s3[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			rprod_s4 <= rprod_c4;
			ang_s4   <= ang_c4;
			xo_s4    <= sat16(xs_c4[VEC_W-1:14]);
			yo_s4    <= sat16(ys_c4[VEC_W-1:14]);
			mode_s4  <= cm_s3[N-1];
			kill_s4  <= ck_s3[N-1];
			err_s4   <= ce_s3[N-1];
		end
	end

	// ---------------- stage 5: output register ----------------
	logic [61:0]        rsum_c5;
	logic [17:0]        rr_c5;
	logic [15:0]        rad_c5;

	logic [15:0]        rad_s5, ang_s5, xo_s5, yo_s5;
	logic               err_s5;

	assign rsum_c5 = {1'b0, rprod_s4} + (62'd1 << 43);
	assign rr_c5   = rsum_c5[61:44];
	assign rad_c5  = (rr_c5 > 18'd65535) ? 16'hFFFF : rr_c5[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			// zero the fields that do not belong to the mode, and all fields on error or origin
			rad_s5 <= (!mode_s4 && !kill_s4) ? rad_c5 : 16'd0;
			ang_s5 <= (!mode_s4 && !kill_s4) ? ang_s4 : 16'd0;
			xo_s5  <= (mode_s4 && !kill_s4) ? xo_s4 : 16'd0;
			yo_s5  <= (mode_s4 && !kill_s4) ? yo_s4 : 16'd0;
			err_s5 <= err_s4;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {yo_s5, xo_s5, ang_s5, rad_s5};
	assign m_tuser  = err_s5;

	// ---------------- assertions ----------------
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register is empty");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
		else $error("range error result carries nonzero data");

	a_mode_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:0] == 32'd0 || m_tdata[63:32] == 32'd0)
		else $error("polar and rectangular fields both nonzero");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[31:16]) <= PI_Q13 && $signed(m_tdata[31:16]) >= -PI_Q13)
		else $error("angle outside +/-pi");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !m_tready && v_s4 |=> v_s4 && $stable(rprod_s4))
		else $error("stage 4 moved while output stalled");

endmodule

// File: sim/rect_polar_converter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rect_polar_converter: directed and random conversions in
// both modes, with random idling on both stream sides. Needs the RTL and rpc_pkg only.
module rect_polar_converter_test;

	localparam int     STEPS       = 16;
	localparam int     ATAN_LEN    = 24;
	localparam int     LATENCY     = STEPS + 4;
	localparam int     CYCLE_LIMIT = 600000;
	localparam longint CORDIC_GAIN = 64'sh26DD3B6A;
	localparam longint QUARTER_TURN = 64'sh6487ED51;
	localparam longint PI_ANGLE    = 25736;
	localparam logic   MODE_RECT_TO_POLAR = 1'b0;
	localparam logic   MODE_POLAR_TO_RECT = 1'b1;

	typedef struct packed {
		logic [15:0]        radius;
		logic signed [15:0] angle;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               range_err;
	} conversion_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [15:0] first_value, [31:16] second_value
	logic [0:0]  s_tuser;   // [0] mode
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [15:0] radius_out, [31:16] angle_out, [47:32] x_out, [63:48] y_out
	logic [0:0]  m_tuser;   // [0] range_error

	// atan(2^-i) in 30 fraction bits, truncated
	longint atan_q30 [0:ATAN_LEN-1] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	conversion_t pending_results[$];
	int          fail_count;
	int          rect_count;
	int          polar_count;
	int          range_err_count;
	int          checked_count;
	int          cycle_count;
	bit          src_idle_en;
	bit          sink_stall_en;
	int          stall_left;

	rect_polar_converter #(
		.ITERATIONS(STEPS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic conversion_t predict_conversion(input logic mode,
			input logic signed [15:0] first_val, input logic signed [15:0] second_val);
		conversion_t r;
		longint      a, b, x, y, z, nx, ny;
		int          n, i;
		r = '0;
		a = first_val;
		b = second_val;
		n = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
		if (mode == MODE_RECT_TO_POLAR) begin
			if (a == 0 && b == 0)
				return r;
			x = a * 16384;
			y = b * 16384;
			z = 0;
			// fold the left half plane into the right one
			if (x < 0) begin
				if (y >= 0) begin
					nx = y;
					ny = -x;
					z  = QUARTER_TURN;
				end else begin
					nx = -y;
					ny = x;
					z  = -QUARTER_TURN;
				end
				x = nx;
				y = ny;
			end
			for (i = 0; i < n; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z  = z + atan_q30[i];
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z  = z - atan_q30[i];
				end
				x = nx;
				y = ny;
			end
			x = (x * CORDIC_GAIN + (longint'(1) << 43)) >>> 44;
			z = (z + (longint'(1) << 16)) >>> 17;
			r.radius = 16'(clip(x, 0, 65535));
			r.angle  = 16'(clip(z, -PI_ANGLE, PI_ANGLE));
			return r;
		end
		if (a < 0 || b > PI_ANGLE || b < -PI_ANGLE) begin
			r.range_err = 1'b1;
			return r;
		end
		x = (a * 16384 * CORDIC_GAIN + (longint'(1) << 29)) >>> 30;
		y = 0;
		z = b * 131072;
		if (z > QUARTER_TURN) begin
			y = x;
			x = 0;
			z = z - QUARTER_TURN;
		end else if (z < -QUARTER_TURN) begin
			y = -x;
			x = 0;
			z = z + QUARTER_TURN;
		end
		for (i = 0; i < n; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z  = z - atan_q30[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z  = z + atan_q30[i];
			end
			x = nx;
			y = ny;
		end
		x = (x + (longint'(1) << 13)) >>> 14;
		y = (y + (longint'(1) << 13)) >>> 14;
		r.x = 16'(clip(x, -32768, 32767));
		r.y = 16'(clip(y, -32768, 32767));
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return 0;
		if (sel < 88)
			return $urandom_range(1, 3);
		if (sel < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_coord();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			case ($urandom_range(0, 4))
				0:       return 16'h8000;
				1:       return 16'h7FFF;
				2:       return 16'hFFFF;
				3:       return 16'h0001;
				default: return 16'h0000;
			endcase
		end
		if (sel < 3)
			return 16'($urandom_range(0, 1024) - 512);
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_radius();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return 16'h0000;
		if (sel == 1)
			return 16'h7FFF;
		if (sel < 4)
			return 16'h8000 | 16'($urandom);
		return 16'($urandom_range(0, 32767));
	endfunction

	function automatic logic [15:0] pick_angle();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return ($urandom_range(0, 1) != 0) ? 16'(PI_ANGLE) : 16'(-PI_ANGLE);
		if (sel == 1)
			return 16'(PI_ANGLE + 1 + $urandom_range(0, 7030));
		if (sel == 2)
			return 16'(-PI_ANGLE - 1 - $urandom_range(0, 7031));
		if (sel == 3)
			return 16'($urandom);
		return 16'($urandom_range(0, 2 * PI_ANGLE) - PI_ANGLE);
	endfunction

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// predict each transaction as it is accepted
	always @(posedge clk) begin
		conversion_t p;
		if (arst_n && s_tvalid && s_tready) begin
			p = predict_conversion(s_tuser[0], s_tdata[15:0], s_tdata[31:16]);
			pending_results.push_back(p);
			if (s_tuser[0] == MODE_RECT_TO_POLAR)
				rect_count++;
			else
				polar_count++;
			if (p.range_err)
				range_err_count++;
		end
	end

	task automatic check_field(input string name, input longint expected, input longint actual);
		if (expected != actual) begin
			$error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		conversion_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no expectation waiting");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				checked_count++;
				check_field("radius_out", e.radius, m_tdata[15:0]);
				check_field("angle_out", e.angle, $signed(m_tdata[31:16]));
				check_field("x_out", e.x, $signed(m_tdata[47:32]));
				check_field("y_out", e.y, $signed(m_tdata[63:48]));
				check_field("range_error", e.range_err, m_tuser[0]);
			end
		end
	end

	// result side: random stalls when enabled, ready otherwise
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if (sink_stall_en && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// called at a falling edge; returns at a falling edge
	task automatic send_sample(input logic mode, input logic [15:0] first_val,
			input logic [15:0] second_val);
		int gap;
		s_tvalid = 1'b1;
		s_tuser  = mode;
		s_tdata  = {second_val, first_val};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		gap = src_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_for_results();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_rect_directed();
		src_idle_en   = 1'b1;
		sink_stall_en = 1'b1;
		send_sample(MODE_RECT_TO_POLAR, 16'sd0, 16'sd0);          // origin
		send_sample(MODE_RECT_TO_POLAR, 16'sd256, 16'sd0);
		send_sample(MODE_RECT_TO_POLAR, 16'sd0, 16'sd256);
		send_sample(MODE_RECT_TO_POLAR, -16'sd256, 16'sd0);       // negative x axis
		send_sample(MODE_RECT_TO_POLAR, -16'sd256, -16'sd256);
		send_sample(MODE_RECT_TO_POLAR, 16'sd0, -16'sd256);
		send_sample(MODE_RECT_TO_POLAR, -16'sd1, 16'sd0);
		send_sample(MODE_RECT_TO_POLAR, 16'sd0, -16'sd1);
		send_sample(MODE_RECT_TO_POLAR, 16'sh7FFF, 16'sh7FFF);
		send_sample(MODE_RECT_TO_POLAR, 16'sh8000, 16'sh8000);
		send_sample(MODE_RECT_TO_POLAR, 16'sh8000, 16'sd0);
		send_sample(MODE_RECT_TO_POLAR, 16'sh7FFF, 16'sh8000);
	endtask

	task automatic test_polar_directed();
		send_sample(MODE_POLAR_TO_RECT, 16'sd256, 16'sd0);
		send_sample(MODE_POLAR_TO_RECT, 16'sd256, 16'(PI_ANGLE));
		send_sample(MODE_POLAR_TO_RECT, 16'sd256, 16'(-PI_ANGLE));
		send_sample(MODE_POLAR_TO_RECT, 16'sd256, 16'(PI_ANGLE + 1));   // beyond pi
		send_sample(MODE_POLAR_TO_RECT, 16'sd256, 16'(-PI_ANGLE - 1));
		send_sample(MODE_POLAR_TO_RECT, -16'sd1, 16'sd0);               // negative radius
		send_sample(MODE_POLAR_TO_RECT, 16'sh8000, 16'sh7FFF);
		send_sample(MODE_POLAR_TO_RECT, 16'sd0, 16'sd0);
		send_sample(MODE_POLAR_TO_RECT, 16'sh7FFF, 16'sd0);
		send_sample(MODE_POLAR_TO_RECT, 16'sh7FFF, 16'sd12868);
		send_sample(MODE_POLAR_TO_RECT, 16'sh7FFF, 16'sd6434);          // diagonal
		send_sample(MODE_POLAR_TO_RECT, 16'sh7FFF, 16'sh8000);
		wait_for_results();
	endtask

	task automatic send_random_sample();
		if ($urandom_range(0, 1) == 0)
			send_sample(MODE_RECT_TO_POLAR, pick_coord(), pick_coord());
		else
			send_sample(MODE_POLAR_TO_RECT, pick_radius(), pick_angle());
	endtask

	// back-to-back traffic with the result side always ready
	task automatic test_full_rate_stream();
		src_idle_en   = 1'b0;
		sink_stall_en = 1'b0;
		repeat (120) send_random_sample();
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		src_idle_en   = 1'b1;
		sink_stall_en = 1'b1;
		for (int k = 0; k < 1000; k++) begin
			send_random_sample();
			// hold off the source until the pipeline has drained
			if (k % 250 == 249)
				wait_for_results();
		end
		wait_for_results();
	endtask

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = '0;
		src_idle_en     = 1'b0;
		sink_stall_en   = 1'b0;
		fail_count      = 0;
		rect_count      = 0;
		polar_count     = 0;
		range_err_count = 0;
		checked_count   = 0;
		cycle_count     = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_rect_directed();
		test_polar_directed();
		test_full_rate_stream();
		test_random_traffic();

		wait_for_results();
		repeat (2 * LATENCY) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		$display("covered %0d rect-to-polar and %0d polar-to-rect transactions (%0d range errors)",
			rect_count, polar_count, range_err_count);
		$display("checked %0d results under random source gaps and result-side stalls",
			checked_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
